// ----- sv/sws_pkg.sv -----
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants of the stop-and-wait sample sender
// Item formats, operation and phase codes, register map, frame bytes, CRC-8.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int DATA_BYTES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int SAMPLE_W        = 64;
    localparam int TIMER_W         = 16;
    localparam int CNT_W           = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_W           = 16;
    localparam int KIND_N          = 3;

    // operations carried by an input item
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SEND    = 2'd1;
    localparam logic [1:0] OP_TX_DONE = 2'd2;
    localparam logic [1:0] OP_RX_BYTE = 2'd3;

    // protocol phases
    localparam logic [1:0] PH_IDLE        = 2'd0;
    localparam logic [1:0] PH_WAIT_TX     = 2'd1;
    localparam logic [1:0] PH_WAIT_ANSWER = 2'd2;

    // failure kinds, also the alarm kind reported
    localparam logic [1:0] KIND_TIMEOUT    = 2'd0;
    localparam logic [1:0] KIND_NAK        = 2'd1;
    localparam logic [1:0] KIND_UNEXPECTED = 2'd2;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INFO_MODE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_TIMEOUT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_NAK         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_UNEXPECTED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_TIMEOUT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_NAK          = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_UNEXPECTED   = 3'd7;

    localparam logic [TIMER_W-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [CNT_W-1:0]   LIMIT_RST   = 4'd3;

    // frame and answer bytes
    localparam logic [7:0] ACK_BYTE   = 8'h06;
    localparam logic [7:0] NAK_BYTE   = 8'h15;
    localparam logic [7:0] END_BYTE   = 8'h0A;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_U     = 8'h55;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    typedef struct packed {
        logic [1:0]          op;
        logic [SAMPLE_W-1:0] sample_word;
        logic [7:0]          answer_byte;
    } in_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] frame_byte;
        logic       last;
        logic       ready_res;
        logic       sample_lost;
        logic       alarm_on;
        logic [1:0] alarm_kind;
    } out_t;

    typedef struct packed {
        logic       ready_res;
        logic       sample_lost;
        logic       alarm_on;
        logic [1:0] alarm_kind;
    } status_t;

    // one classified item handed from front to back
    typedef struct packed {
        logic                           has_frame;
        logic                           info;
        logic [SAMPLE_W-1:0]            sample;
        logic [KIND_N-1:0][CNT_W-1:0]   tries;
        logic [KIND_N-1:0][CNT_W-1:0]   losses;
        status_t                        status;
    } job_t;

    // CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- sv/sws_queue.sv -----
// ----------------------------------------------------------------------------
// sws_queue: short job queue between front and back
// Register-based FIFO; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module sws_queue
    import sws_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    output logic head_valid,
    output job_t head_data,
    input  logic pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    job_t               store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W_Q-1:0] count_reg;

    assign full       = (count_reg == CNT_W_Q'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W_Q'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- sv/sws_front.sv -----
// ----------------------------------------------------------------------------
// sws_front: protocol front end
// Holds configuration and protocol state, classifies each item and queues a job.
// ----------------------------------------------------------------------------
module sws_front
    import sws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_t                  in_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 job_push,
    output job_t                 job,
    input  logic                 queue_full
);

    logic [TIMER_W-1:0]           timeout_reg;
    logic                         info_reg;
    logic [KIND_N-1:0][CNT_W-1:0] rlim_reg;
    logic [KIND_N-1:0][CNT_W-1:0] llim_reg;

    logic [1:0]                   phase_reg, phase_next;
    logic [SAMPLE_W-1:0]          held_reg, held_next;
    logic [TIMER_W-1:0]           timer_reg, timer_next;
    logic [KIND_N-1:0][CNT_W-1:0] tries_reg, tries_next;
    logic [KIND_N-1:0][CNT_W-1:0] lost_reg, lost_next;
    logic                         alarm_reg, alarm_next;
    logic [1:0]                   alarm_type_reg, alarm_type_next;

    logic                         do_fail;
    logic [1:0]                   fail_kind;
    logic                         frame;
    logic                         dropped;
    logic [CNT_W:0]               try_sum;
    logic [CNT_W:0]               loss_sum;

    assign in_ready  = !queue_full;
    assign cfg_ready = 1'b1;
    assign job_push  = in_valid && in_ready;

    always_comb
    begin
        phase_next      = phase_reg;
        held_next       = held_reg;
        timer_next      = timer_reg;
        tries_next      = tries_reg;
        lost_next       = lost_reg;
        alarm_next      = alarm_reg;
        alarm_type_next = alarm_type_reg;
        do_fail         = 1'b0;
        fail_kind       = KIND_TIMEOUT;
        frame           = 1'b0;
        dropped         = 1'b0;
        try_sum         = '0;
        loss_sum        = '0;

        if (job_push)
        begin
            unique case (in_data.op)
                OP_SEND:
                begin
                    held_next  = in_data.sample_word;
                    timer_next = '0;
                    phase_next = PH_WAIT_TX;
                    frame      = 1'b1;
                end
                OP_TX_DONE:
                begin
                    if (phase_reg == PH_WAIT_TX)
                    begin
                        timer_next = timeout_reg;
                        phase_next = PH_WAIT_ANSWER;
                    end
                end
                OP_TICK:
                begin
                    if (phase_reg == PH_WAIT_ANSWER)
                    begin
                        if (timer_reg <= TIMER_W'(1))
                        begin
                            timer_next = '0;
                            do_fail    = 1'b1;
                            fail_kind  = KIND_TIMEOUT;
                        end
                        else
                        begin
                            timer_next = timer_reg - 1'b1;
                        end
                    end
                end
                OP_RX_BYTE:
                begin
                    if (phase_reg == PH_WAIT_ANSWER)
                    begin
                        timer_next = '0;
                        if (in_data.answer_byte == ACK_BYTE)
                        begin
                            tries_next      = '0;
                            lost_next       = '0;
                            alarm_next      = 1'b0;
                            alarm_type_next = KIND_TIMEOUT;
                            phase_next      = PH_IDLE;
                        end
                        else
                        begin
                            do_fail   = 1'b1;
                            fail_kind = (in_data.answer_byte == NAK_BYTE) ? KIND_NAK
                                                                          : KIND_UNEXPECTED;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // count one failed try; resend or drop the sample
        if (do_fail)
        begin
            try_sum = {1'b0, tries_reg[fail_kind]} + 1'b1;
            if (try_sum >= {1'b0, rlim_reg[fail_kind]})
            begin
                tries_next[fail_kind] = '0;
                phase_next            = PH_IDLE;
                dropped               = 1'b1;
                loss_sum              = {1'b0, lost_reg[fail_kind]} + 1'b1;
                if (loss_sum >= {1'b0, llim_reg[fail_kind]})
                begin
                    alarm_next      = 1'b1;
                    alarm_type_next = fail_kind;
                    loss_sum        = {1'b0, llim_reg[fail_kind]};
                end
                lost_next[fail_kind] = loss_sum[CNT_W-1:0];
            end
            else
            begin
                tries_next[fail_kind] = try_sum[CNT_W-1:0];
                phase_next            = PH_WAIT_TX;
                frame                 = 1'b1;
            end
        end
    end

    always_comb
    begin
        job.has_frame          = frame;
        job.info               = info_reg;
        job.sample             = held_next;
        job.tries              = tries_next;
        job.losses             = lost_next;
        job.status.ready_res   = (phase_next == PH_IDLE);
        job.status.sample_lost = dropped;
        job.status.alarm_on    = alarm_next;
        job.status.alarm_kind  = alarm_next ? alarm_type_next : KIND_TIMEOUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            info_reg    <= 1'b0;
            rlim_reg    <= {KIND_N{LIMIT_RST}};
            llim_reg    <= {KIND_N{LIMIT_RST}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TIMEOUT_TICKS:    timeout_reg <= cfg_data;
                REG_INFO_MODE:        info_reg <= cfg_data[0];
                REG_RETRY_TIMEOUT:    rlim_reg[KIND_TIMEOUT] <= cfg_data[CNT_W-1:0];
                REG_RETRY_NAK:        rlim_reg[KIND_NAK] <= cfg_data[CNT_W-1:0];
                REG_RETRY_UNEXPECTED: rlim_reg[KIND_UNEXPECTED] <= cfg_data[CNT_W-1:0];
                REG_LOSS_TIMEOUT:     llim_reg[KIND_TIMEOUT] <= cfg_data[CNT_W-1:0];
                REG_LOSS_NAK:         llim_reg[KIND_NAK] <= cfg_data[CNT_W-1:0];
                REG_LOSS_UNEXPECTED:  llim_reg[KIND_UNEXPECTED] <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            held_reg       <= '0;
            timer_reg      <= '0;
            tries_reg      <= '0;
            lost_reg       <= '0;
            alarm_reg      <= 1'b0;
            alarm_type_reg <= KIND_TIMEOUT;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            timer_reg      <= timer_next;
            tries_reg      <= tries_next;
            lost_reg       <= lost_next;
            alarm_reg      <= alarm_next;
            alarm_type_reg <= alarm_type_next;
        end
    end

    a_send_waits_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (job_push && in_data.op == OP_SEND) |=> phase_reg == PH_WAIT_TX)
        else $error("send item did not enter transmit wait");

    a_idle_timer_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> timer_reg == '0)
        else $error("timer running while idle");

    a_alarm_kind_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !alarm_reg |-> alarm_type_reg == KIND_TIMEOUT)
        else $error("alarm kind set without alarm");

endmodule

// ----- sv/sws_back.sv -----
// ----------------------------------------------------------------------------
// sws_back: frame emitter
// Takes jobs from the queue and emits one result per cycle while the receiver is ready, CRC on the fly.
// ----------------------------------------------------------------------------
module sws_back
    import sws_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    input  job_t job,
    output logic job_pop,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int IDX_W     = $clog2(DATA_BYTES + 11);
    localparam int PRE_SHIFT = 8 * (8 - DATA_BYTES);
    localparam logic [IDX_W-1:0] IDX_CRC        = IDX_W'(DATA_BYTES);
    localparam logic [IDX_W-1:0] IDX_FIRST_INFO = IDX_W'(DATA_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_LAST_PLAIN = IDX_W'(DATA_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_LAST_INFO  = IDX_W'(DATA_BYTES + 10);

    logic                         busy_reg;
    logic                         out_valid_reg;
    out_t                         out_data_reg;
    logic [SAMPLE_W-1:0]          shift_reg;
    logic [7:0]                   crc_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         info_reg;
    logic [KIND_N-1:0][CNT_W-1:0] tries_reg;
    logic [KIND_N-1:0][CNT_W-1:0] losses_reg;
    status_t                      status_reg;

    logic                         advance;
    logic                         emit_frame;
    logic                         emit_plain;
    logic                         load;
    logic [IDX_W-1:0]             last_idx;
    logic                         at_last;
    logic [3:0]                   digit_pos;
    logic [7:0]                   info_byte;
    logic [7:0]                   cur_byte;
    logic [7:0]                   data_byte;

    assign advance    = !out_valid_reg || out_ready;
    assign emit_frame = busy_reg && advance;
    assign emit_plain = !busy_reg && job_valid && !job.has_frame && advance;
    assign load       = !busy_reg && job_valid && job.has_frame;
    assign job_pop    = emit_plain || load;

    assign last_idx  = info_reg ? IDX_LAST_INFO : IDX_LAST_PLAIN;
    assign at_last   = (idx_reg == last_idx);
    assign digit_pos = 4'(idx_reg - IDX_FIRST_INFO);
    assign data_byte = shift_reg[SAMPLE_W-1 -: 8];

    always_comb
    begin
        case (digit_pos)
            4'd0:    info_byte = CHAR_T;
            4'd1:    info_byte = DIGIT_ZERO + {4'b0, losses_reg[KIND_TIMEOUT]};
            4'd2:    info_byte = DIGIT_ZERO + {4'b0, tries_reg[KIND_TIMEOUT]};
            4'd3:    info_byte = CHAR_N;
            4'd4:    info_byte = DIGIT_ZERO + {4'b0, losses_reg[KIND_NAK]};
            4'd5:    info_byte = DIGIT_ZERO + {4'b0, tries_reg[KIND_NAK]};
            4'd6:    info_byte = CHAR_U;
            4'd7:    info_byte = DIGIT_ZERO + {4'b0, losses_reg[KIND_UNEXPECTED]};
            4'd8:    info_byte = DIGIT_ZERO + {4'b0, tries_reg[KIND_UNEXPECTED]};
            default: info_byte = END_BYTE;
        endcase

        if (idx_reg < IDX_CRC)
        begin
            cur_byte = data_byte;
        end
        else if (idx_reg == IDX_CRC)
        begin
            cur_byte = crc_reg;
        end
        else if (at_last)
        begin
            cur_byte = END_BYTE;
        end
        else
        begin
            cur_byte = info_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit_frame && at_last)
            begin
                busy_reg <= 1'b0;
            end

            if (emit_frame || emit_plain)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg  <= job.sample << PRE_SHIFT;
            crc_reg    <= '0;
            idx_reg    <= '0;
            info_reg   <= job.info;
            tries_reg  <= job.tries;
            losses_reg <= job.losses;
            status_reg <= job.status;
        end
        else if (emit_frame)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg < IDX_CRC)
            begin
                crc_reg   <= crc8_byte(crc_reg, data_byte);
                shift_reg <= shift_reg << 8;
            end
        end

        if (emit_frame)
        begin
            out_data_reg.has_byte    <= 1'b1;
            out_data_reg.frame_byte  <= cur_byte;
            out_data_reg.last        <= at_last;
            out_data_reg.ready_res   <= status_reg.ready_res;
            out_data_reg.sample_lost <= status_reg.sample_lost;
            out_data_reg.alarm_on    <= status_reg.alarm_on;
            out_data_reg.alarm_kind  <= status_reg.alarm_kind;
        end
        else if (emit_plain)
        begin
            out_data_reg.has_byte    <= 1'b0;
            out_data_reg.frame_byte  <= '0;
            out_data_reg.last        <= 1'b1;
            out_data_reg.ready_res   <= job.status.ready_res;
            out_data_reg.sample_lost <= job.status.sample_lost;
            out_data_reg.alarm_on    <= job.status.alarm_on;
            out_data_reg.alarm_kind  <= job.status.alarm_kind;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= last_idx)
        else $error("frame index past end of frame");

    a_empty_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.has_byte) |->
            (out_data_reg.last && out_data_reg.frame_byte == '0))
        else $error("result without byte is not a single last result");

    a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && idx_reg == '0))
        else $error("frame did not start at first byte");

endmodule

// ----- sv/stop_and_wait_sample_sender.sv -----
// ----------------------------------------------------------------------------
// stop_and_wait_sample_sender: stop-and-wait sender for sample words
// Front end runs the retry/loss protocol; back end emits framed bytes.
// ----------------------------------------------------------------------------
// Path: an item without a frame goes through the job queue and the output
// register; a framed item is loaded into the back end before its first byte.
// Throughput: one item per cycle for items without a frame while out_ready is high;
// a frame holds the back end until its end byte is out, one byte a cycle while ready.
// Reset: configuration returns to its defaults, all counters, timer and alarm
// clear, the job queue empties; the block accepts items straight after reset.
module stop_and_wait_sample_sender
    import sws_pkg::*;
#(
    parameter int DATA_BYTES  = DATA_BYTES_DEF,   // 1 to 8
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF   // 2 or more
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_t                 out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic job_push;
    job_t job_in;
    logic queue_full;
    logic head_valid;
    job_t head_job;
    logic head_pop;

    sws_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .job_push   (job_push),
        .job        (job_in),
        .queue_full (queue_full)
    );

    sws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_data  (job_in),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_job),
        .pop        (head_pop)
    );

    sws_back #(
        .DATA_BYTES (DATA_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .job_pop   (head_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- tb/sv/tb_stop_and_wait_sample_sender.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stop_and_wait_sample_sender: self-checking bench for the sample sender
// A short table of protocol events opens the run. Random exchanges follow
// under six register settings, with random stalls on both channels and one
// long receiver hold-off. Every frame byte and status item is predicted, by a
// behavioural copy of the sender or by the table, and checked in order.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_sample_sender;
    import sws_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int PER_SETTING   = 33;
    localparam int SETTING_COUNT = 6;
    localparam int LONG_HOLD     = 120;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_LIMIT  = 10;
    localparam int RUN_LIMIT_NS  = 4_000_000;

    // single status items that can be read straight off the protocol
    localparam out_t NOTE_IDLE = '{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 2'd0};
    localparam out_t NOTE_BUSY = '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0};
    localparam out_t NOTE_DROP = '{1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 2'd0};

    localparam logic [KIND_N-1:0][7:0] KIND_MARK = {CHAR_U, CHAR_N, CHAR_T};

    typedef struct packed {
        in_t  item;
        logic typed;
        out_t note;
    } row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_t                  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_t                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // sender copy: registers
    logic [TIMER_W-1:0] cfg_ticks             = TIMEOUT_RST;
    logic               cfg_info              = 1'b0;
    logic [CNT_W-1:0]   retry_cap [KIND_N]    = '{LIMIT_RST, LIMIT_RST, LIMIT_RST};
    logic [CNT_W-1:0]   loss_cap  [KIND_N]    = '{LIMIT_RST, LIMIT_RST, LIMIT_RST};

    // sender copy: protocol state
    logic [1:0]          phase_now  = PH_IDLE;
    logic [SAMPLE_W-1:0] held_word  = '0;
    logic [TIMER_W-1:0]  wait_left  = '0;
    logic [CNT_W-1:0]    tries_of  [KIND_N] = '{4'd0, 4'd0, 4'd0};
    logic [CNT_W-1:0]    losses_of [KIND_N] = '{4'd0, 4'd0, 4'd0};
    logic                alarm_up   = 1'b0;
    logic [1:0]          alarm_sort = '0;

    logic [7:0] frame_bytes [$];
    out_t       pending_results [$];
    row_t       script [$];

    logic typed_pending = 1'b0;
    out_t typed_note    = '0;
    logic took_effect   = 1'b0;
    logic hold_flag     = 1'b0;
    logic calm          = 1'b0;

    int failures      = 0;
    int items_taken   = 0;
    int results_seen  = 0;
    int drops_seen    = 0;
    int alarm_drops   = 0;

    stop_and_wait_sample_sender uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sender copy
    // ------------------------------------------------------------------
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ data[i];
            r  = {r[6:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    task automatic build_frame();
        logic [7:0] crc;
        logic [7:0] b;
        frame_bytes.delete();
        crc = '0;
        for (int i = 0; i < DATA_BYTES_DEF; i++)
        begin
            b = held_word[8*(DATA_BYTES_DEF-1-i) +: 8];
            frame_bytes.push_back(b);
            crc = crc8_step(crc, b);
        end
        frame_bytes.push_back(crc);
        if (cfg_info)
        begin
            for (int k = 0; k < KIND_N; k++)
            begin
                frame_bytes.push_back(KIND_MARK[k]);
                frame_bytes.push_back(DIGIT_ZERO + {4'd0, losses_of[k]});
                frame_bytes.push_back(DIGIT_ZERO + {4'd0, tries_of[k]});
            end
        end
        frame_bytes.push_back(END_BYTE);
    endtask

    // one failed try of a kind; high when the sample is dropped
    function automatic logic count_failure(input logic [1:0] kind);
        logic [CNT_W:0] tries_next;
        logic [CNT_W:0] lost_next;
        tries_next = {1'b0, tries_of[kind]} + 1'b1;
        if (tries_next >= {1'b0, retry_cap[kind]})
        begin
            lost_next      = {1'b0, losses_of[kind]} + 1'b1;
            tries_of[kind] = '0;
            phase_now      = PH_IDLE;
            if (lost_next >= {1'b0, loss_cap[kind]})
            begin
                alarm_up   = 1'b1;
                alarm_sort = kind;
                lost_next  = {1'b0, loss_cap[kind]};
            end
            losses_of[kind] = lost_next[CNT_W-1:0];
            return 1'b1;
        end
        tries_of[kind] = tries_next[CNT_W-1:0];
        phase_now      = PH_WAIT_TX;
        return 1'b0;
    endfunction

    task automatic store_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        case (idx)
            REG_TIMEOUT_TICKS:    cfg_ticks = value;
            REG_INFO_MODE:        cfg_info = value[0];
            REG_RETRY_TIMEOUT:    retry_cap[KIND_TIMEOUT] = value[CNT_W-1:0];
            REG_RETRY_NAK:        retry_cap[KIND_NAK] = value[CNT_W-1:0];
            REG_RETRY_UNEXPECTED: retry_cap[KIND_UNEXPECTED] = value[CNT_W-1:0];
            REG_LOSS_TIMEOUT:     loss_cap[KIND_TIMEOUT] = value[CNT_W-1:0];
            REG_LOSS_NAK:         loss_cap[KIND_NAK] = value[CNT_W-1:0];
            REG_LOSS_UNEXPECTED:  loss_cap[KIND_UNEXPECTED] = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_sender_step(input in_t x);
        logic dropped;
        int   n;
        out_t r;
        dropped     = 1'b0;
        took_effect = 1'b0;
        frame_bytes.delete();
        case (x.op)
            OP_SEND:
            begin
                held_word   = x.sample_word;
                wait_left   = '0;
                phase_now   = PH_WAIT_TX;
                took_effect = 1'b1;
                build_frame();
            end
            OP_TX_DONE:
            begin
                if (phase_now == PH_WAIT_TX)
                begin
                    wait_left   = cfg_ticks;
                    phase_now   = PH_WAIT_ANSWER;
                    took_effect = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (phase_now == PH_WAIT_ANSWER)
                begin
                    took_effect = 1'b1;
                    if (wait_left <= 16'd1)
                    begin
                        wait_left = '0;
                        dropped   = count_failure(KIND_TIMEOUT);
                        if (!dropped)
                            build_frame();
                    end
                    else
                        wait_left = wait_left - 16'd1;
                end
            end
            default:
            begin
                if (phase_now == PH_WAIT_ANSWER)
                begin
                    took_effect = 1'b1;
                    wait_left   = '0;
                    if (x.answer_byte == ACK_BYTE)
                    begin
                        for (int k = 0; k < KIND_N; k++)
                        begin
                            tries_of[k]  = '0;
                            losses_of[k] = '0;
                        end
                        alarm_up   = 1'b0;
                        alarm_sort = '0;
                        phase_now  = PH_IDLE;
                    end
                    else
                    begin
                        dropped = count_failure(x.answer_byte == NAK_BYTE ?
                                                KIND_NAK : KIND_UNEXPECTED);
                        if (!dropped)
                            build_frame();
                    end
                end
            end
        endcase

        n = (frame_bytes.size() > 0) ? frame_bytes.size() : 1;
        for (int k = 0; k < n; k++)
        begin
            r.has_byte    = frame_bytes.size() > 0;
            r.frame_byte  = r.has_byte ? frame_bytes[k] : 8'h00;
            r.last        = (k == n - 1);
            r.ready_res   = (phase_now == PH_IDLE);
            r.sample_lost = dropped;
            r.alarm_on    = alarm_up;
            r.alarm_kind  = alarm_up ? alarm_sort : '0;
            pending_results.push_back(r);
        end
        if (dropped)
        begin
            drops_seen++;
            if (alarm_up)
                alarm_drops++;
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    function automatic string describe(input out_t r);
        return $sformatf("byte %0b/%h last %0b ready %0b lost %0b alarm %0b/%0d",
                         r.has_byte, r.frame_byte, r.last, r.ready_res,
                         r.sample_lost, r.alarm_on, r.alarm_kind);
    endfunction

    task automatic check_result(input out_t got);
        out_t want;
        if (pending_results.size() == 0)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("[%0t] result with nothing pending: %s", $time, describe(got));
        end
        else
        begin
            want = pending_results.pop_front();
            results_seen++;
            if (got.has_byte !== want.has_byte || got.frame_byte !== want.frame_byte ||
                got.last !== want.last || got.ready_res !== want.ready_res ||
                got.sample_lost !== want.sample_lost || got.alarm_on !== want.alarm_on ||
                got.alarm_kind !== want.alarm_kind)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("[%0t] mismatch: expected %s, got %s",
                             $time, describe(want), describe(got));
            end
        end
    endtask

    task automatic accept_item(input in_t x);
        int depth_before;
        depth_before = pending_results.size();
        predict_sender_step(x);
        if (typed_pending)
        begin
            // replace the predicted items with the one read off the table
            while (pending_results.size() > depth_before)
                pending_results.delete(pending_results.size() - 1);
            pending_results.push_back(typed_note);
            typed_pending = 1'b0;
        end
        items_taken++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (cfg_valid && cfg_ready)
                store_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                accept_item(in_data);
        end
    end

    // ------------------------------------------------------------------
    // drivers; every task starts and ends on a falling edge
    // ------------------------------------------------------------------
    task automatic offer(input in_t x);
        in_valid <= 1'b1;
        in_data  <= x;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic program_setting(input logic [TIMER_W-1:0] ticks, input logic info,
                                   input logic [CNT_W-1:0] rt, input logic [CNT_W-1:0] rn,
                                   input logic [CNT_W-1:0] ru, input logic [CNT_W-1:0] lt,
                                   input logic [CNT_W-1:0] ln, input logic [CNT_W-1:0] lu);
        cfg_write(REG_TIMEOUT_TICKS, ticks);
        cfg_write(REG_INFO_MODE, {15'd0, info});
        cfg_write(REG_RETRY_TIMEOUT, {12'd0, rt});
        cfg_write(REG_RETRY_NAK, {12'd0, rn});
        cfg_write(REG_RETRY_UNEXPECTED, {12'd0, ru});
        cfg_write(REG_LOSS_TIMEOUT, {12'd0, lt});
        cfg_write(REG_LOSS_NAK, {12'd0, ln});
        cfg_write(REG_LOSS_UNEXPECTED, {12'd0, lu});
        cfg_valid <= 1'b0;
    endtask

    // drop valid, let every pending item drain, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic add_row(input logic [1:0] op, input logic [SAMPLE_W-1:0] word,
                           input logic [7:0] answer, input logic typed, input out_t note);
        row_t r;
        r.item.op          = op;
        r.item.sample_word = word;
        r.item.answer_byte = answer;
        r.typed            = typed;
        r.note             = note;
        script.push_back(r);
    endtask

    // mostly well-formed exchanges, steered by the current protocol phase
    function automatic in_t pick_item();
        in_t x;
        int  r;
        x.op          = OP_TICK;
        x.sample_word = {$urandom, $urandom};
        x.answer_byte = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10)
            x.op = 2'($urandom_range(0, 3));
        else if (phase_now == PH_IDLE)
            x.op = OP_SEND;
        else if (phase_now == PH_WAIT_TX)
            x.op = (r < 18) ? OP_SEND : OP_TX_DONE;
        else if (r < 40)
            x.op = OP_TICK;
        else
        begin
            x.op = OP_RX_BYTE;
            if (r < 58)
                x.answer_byte = ACK_BYTE;
            else if (r < 78)
                x.answer_byte = NAK_BYTE;
        end
        return x;
    endfunction

    // receiver: short random stalls, one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_flag)
            begin
                hold_flag = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int acted;

        // events in the wrong phase, a clean exchange, NAK and unexpected drops,
        // send while busy, extremes of the sample and answer bytes
        add_row(OP_TICK,    64'h0, 8'h00, 1'b1, NOTE_IDLE);
        add_row(OP_TX_DONE, 64'h0, 8'h00, 1'b1, NOTE_IDLE);
        add_row(OP_RX_BYTE, 64'h0, ACK_BYTE, 1'b1, NOTE_IDLE);
        add_row(OP_SEND,    64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, '0);
        add_row(OP_TICK,    64'h0, 8'h00, 1'b1, NOTE_BUSY);
        add_row(OP_RX_BYTE, 64'h0, 8'hFF, 1'b1, NOTE_BUSY);
        add_row(OP_TX_DONE, 64'h0, 8'h00, 1'b1, NOTE_BUSY);
        add_row(OP_TICK,    64'h0, 8'h00, 1'b1, NOTE_BUSY);
        add_row(OP_RX_BYTE, 64'h0, ACK_BYTE, 1'b1, NOTE_IDLE);
        add_row(OP_SEND,    64'h0, 8'h00, 1'b0, '0);
        add_row(OP_TX_DONE, 64'h0, 8'h00, 1'b1, NOTE_BUSY);
        add_row(OP_RX_BYTE, 64'h0, NAK_BYTE, 1'b0, '0);
        add_row(OP_TX_DONE, 64'h0, 8'h00, 1'b1, NOTE_BUSY);
        add_row(OP_RX_BYTE, 64'h0, NAK_BYTE, 1'b0, '0);
        add_row(OP_TX_DONE, 64'h0, 8'h00, 1'b1, NOTE_BUSY);
        add_row(OP_RX_BYTE, 64'h0, NAK_BYTE, 1'b1, NOTE_DROP);
        add_row(OP_SEND,    64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, '0);
        add_row(OP_SEND,    64'h8000_0000_0000_0001, 8'h00, 1'b0, '0);
        add_row(OP_TX_DONE, 64'h0, 8'h00, 1'b1, NOTE_BUSY);
        add_row(OP_RX_BYTE, 64'h0, 8'h00, 1'b0, '0);
        add_row(OP_TX_DONE, 64'h0, 8'h00, 1'b1, NOTE_BUSY);
        add_row(OP_RX_BYTE, 64'h0, 8'h80, 1'b0, '0);
        add_row(OP_TX_DONE, 64'h0, 8'h00, 1'b1, NOTE_BUSY);
        add_row(OP_RX_BYTE, 64'h0, 8'h7F, 1'b1, NOTE_DROP);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            maybe_gap();
            typed_pending = script[i].typed;
            typed_note    = script[i].note;
            offer(script[i].item);
        end

        for (int s = 0; s < SETTING_COUNT; s++)
        begin
            drain();
            case (s)
                0: program_setting(16'd1, 1'b1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1);
                1: program_setting(16'hFFFF, 1'b0, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9);
                // drop on every failure so the loss counters climb
                2: program_setting(16'd2, 1'b1, 4'd1, 4'd1, 4'd1, 4'd9, 4'd9, 4'd9);
                // lower the loss limits beneath the counters just built up
                3: program_setting(16'd3, 1'b1, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1);
                // zero timeout and zero limits
                4: program_setting(16'd0, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
                default:
                    program_setting(16'($urandom_range(1, 4)), 1'($urandom_range(0, 1)),
                                    4'($urandom_range(1, 9)), 4'($urandom_range(1, 9)),
                                    4'($urandom_range(1, 9)), 4'($urandom_range(1, 9)),
                                    4'($urandom_range(1, 9)), 4'($urandom_range(1, 9)));
            endcase
            if (s == 2)
                hold_flag = 1'b1;
            if (s == SETTING_COUNT - 1)
                calm = 1'b1;
            acted = 0;
            while (acted < PER_SETTING)
            begin
                maybe_gap();
                offer(pick_item());
                if (took_effect)
                    acted++;
            end
        end

        drain();
        $display("Covered %0d items over %0d register settings and %0d results checked;",
                 items_taken, SETTING_COUNT + 1, results_seen);
        $display("%0d samples dropped, %0d of them with an alarm standing.",
                 drops_seen, alarm_drops);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/sws_pkg.sv
sv/sws_queue.sv
sv/sws_front.sv
sv/sws_back.sv
sv/stop_and_wait_sample_sender.sv
tb/sv/tb_stop_and_wait_sample_sender.sv
